[hdl/svg_pkg.sv]
// Shared types, constants and tables for the shape vertex generator.
// Depends on nothing; every other file refers to it by scoped names.
package svg_pkg;

  // Field widths
  localparam int IDX_W   = 11;
  localparam int KIND_W  = 3;
  localparam int DIM_W   = 25;
  localparam int CTR_W   = 26;
  localparam int POS_W   = 27;
  localparam int TEX_W   = 17;
  localparam int RATIO_W = 17;
  localparam int REG_W   = 3;
  localparam int DATA_W  = 26;

  // Arc and arithmetic constants
  localparam int MAX_SEGMENTS = 1024;
  localparam int MIN_SEGMENTS = 3;
  localparam int DIV_STEPS    = 32;
  localparam int CORDIC_STEPS = 16;
  localparam int CW           = 34;
  localparam int DIR_W        = 18;
  localparam int UW           = 21;
  localparam int RDIV_STEPS   = 42;
  localparam int RCNT_W       = 6;

  localparam logic signed [CW-1:0] GAIN_Q30     = 34'sd652032874;
  localparam logic [31:0]          QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0]          EIGHTH_TURN  = 32'h2000_0000;
  localparam logic signed [DIR_W-1:0] UNIT_ONE  = 18'sd65536;
  localparam logic signed [POS_W-1:0] POS_MAX   = 27'sd67108863;
  localparam logic signed [POS_W-1:0] POS_MIN   = -27'sd67108864;

  // Shape kinds
  localparam logic [KIND_W-1:0] KIND_RECT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_CIRC = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TRI  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_RTRI = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CAPS = 3'd4;

  // Register indexes
  localparam logic [REG_W-1:0] REG_KIND     = 3'd0;
  localparam logic [REG_W-1:0] REG_SEGMENTS = 3'd1;
  localparam logic [REG_W-1:0] REG_WIDTH    = 3'd2;
  localparam logic [REG_W-1:0] REG_HEIGHT   = 3'd3;
  localparam logic [REG_W-1:0] REG_CENTER_X = 3'd4;
  localparam logic [REG_W-1:0] REG_CENTER_Y = 3'd5;

  // Corner coordinate codes (two-bit signed)
  localparam logic [1:0] CRN_NEG  = 2'b11;
  localparam logic [1:0] CRN_ZERO = 2'b00;
  localparam logic [1:0] CRN_POS  = 2'b01;

  // Settled configuration as seen by the front and back
  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic [IDX_W-1:0]        n;
    logic [IDX_W-1:0]        m;
    logic [IDX_W-1:0]        half;
    logic                    vert;
    logic [DIM_W-1:0]        width;
    logic [DIM_W-1:0]        height;
    logic signed [CTR_W-1:0] center_x;
    logic signed [CTR_W-1:0] center_y;
    logic [RATIO_W-1:0]      rx;
    logic [RATIO_W-1:0]      ry;
    logic [RATIO_W-1:0]      bar;
  } cfg_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic             in_range;
    logic             last;
    logic             arc;
    logic             caps;
    logic             back_q;
    logic             neg;
    logic [1:0]       corner_x;
    logic [1:0]       corner_y;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] den;
  } item_t;

  // Arctangent of 2^-k in 32-bit turn fractions
  function automatic logic [31:0] atan_turn(input logic [4:0] k);
    logic [31:0] r;
    unique case (k)
      5'd0:    r = 32'h2000_0000;
      5'd1:    r = 32'h12E4_051E;
      5'd2:    r = 32'h09FB_385B;
      5'd3:    r = 32'h0511_11D4;
      5'd4:    r = 32'h028B_0D43;
      5'd5:    r = 32'h0145_D7E1;
      5'd6:    r = 32'h00A2_F61E;
      5'd7:    r = 32'h0051_7C55;
      5'd8:    r = 32'h0028_BE53;
      5'd9:    r = 32'h0014_5F2F;
      5'd10:   r = 32'h000A_2F98;
      5'd11:   r = 32'h0005_17CC;
      5'd12:   r = 32'h0002_8BE6;
      5'd13:   r = 32'h0001_45F3;
      5'd14:   r = 32'h0000_A2FA;
      5'd15:   r = 32'h0000_517D;
      5'd16:   r = 32'h0000_28BE;
      5'd17:   r = 32'h0000_145F;
      5'd18:   r = 32'h0000_0A30;
      5'd19:   r = 32'h0000_0518;
      5'd20:   r = 32'h0000_028C;
      5'd21:   r = 32'h0000_0146;
      5'd22:   r = 32'h0000_00A3;
      5'd23:   r = 32'h0000_0051;
      default: r = 32'h0000_0000;
    endcase
    return r;
  endfunction

endpackage

[hdl/svg_if.sv]
// Valid/ready channel interfaces: vertex requests, vertex results, register writes.
// Depends on svg_pkg for field widths.

interface svg_req_if;
  logic                      valid;
  logic                      ready;
  logic [svg_pkg::IDX_W-1:0] vertex_index;
  modport source (output valid, vertex_index, input ready);
  modport sink   (input valid, vertex_index, output ready);
endinterface

interface svg_rsp_if;
  logic                             valid;
  logic                             ready;
  logic signed [svg_pkg::POS_W-1:0] pos_x;
  logic signed [svg_pkg::POS_W-1:0] pos_y;
  logic [svg_pkg::TEX_W-1:0]        tex_u;
  logic [svg_pkg::TEX_W-1:0]        tex_v;
  logic                             in_range;
  logic                             last_vertex;
  modport source (output valid, pos_x, pos_y, tex_u, tex_v, in_range, last_vertex,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, tex_u, tex_v, in_range, last_vertex,
                  output ready);
endinterface

interface svg_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [svg_pkg::REG_W-1:0]  index;
  logic [svg_pkg::DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/svg_cfg.sv]
// Configuration registers and the capsule ratio divider (bit-serial, three lanes).
// Depends on svg_pkg and svg_cfg_if.
module svg_cfg (
  input  logic          clk,
  input  logic          rst,
  svg_cfg_if.sink       cfg,
  output svg_pkg::cfg_t cur,
  output logic          busy
);

  logic [svg_pkg::KIND_W-1:0]       kind;
  logic [svg_pkg::IDX_W-1:0]        segments;
  logic [svg_pkg::DIM_W-1:0]        width;
  logic [svg_pkg::DIM_W-1:0]        height;
  logic signed [svg_pkg::CTR_W-1:0] center_x;
  logic signed [svg_pkg::CTR_W-1:0] center_y;

  logic                             start;
  logic [svg_pkg::RCNT_W-1:0]       cnt;
  logic [svg_pkg::RDIV_STEPS-1:0]   dvd [3];
  logic [svg_pkg::DIM_W:0]          rem [3];
  logic [svg_pkg::RATIO_W-1:0]      quo [3];
  logic [svg_pkg::DIM_W:0]          den [3];
  logic [svg_pkg::DIM_W-1:0]        rad;
  logic [svg_pkg::DIM_W:0]          len;
  logic [svg_pkg::IDX_W-1:0]        n;
  logic [svg_pkg::RATIO_W-1:0]      ratio [3];

  assign cfg.ready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kind     <= svg_pkg::KIND_RECT;
      segments <= 11'd32;
      width    <= 25'd2560;
      height   <= 25'd2560;
      center_x <= '0;
      center_y <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        svg_pkg::REG_KIND:     kind     <= cfg.data[svg_pkg::KIND_W-1:0];
        svg_pkg::REG_SEGMENTS: segments <= cfg.data[svg_pkg::IDX_W-1:0];
        svg_pkg::REG_WIDTH:    width    <= cfg.data[svg_pkg::DIM_W-1:0];
        svg_pkg::REG_HEIGHT:   height   <= cfg.data[svg_pkg::DIM_W-1:0];
        svg_pkg::REG_CENTER_X: center_x <= cfg.data;
        svg_pkg::REG_CENTER_Y: center_y <= cfg.data;
        default: ;
      endcase
    end
  end

  // Derived segment counts and capsule geometry
  always_comb begin
    if (segments < 11'(svg_pkg::MIN_SEGMENTS))      n = 11'(svg_pkg::MIN_SEGMENTS);
    else if (segments > 11'(svg_pkg::MAX_SEGMENTS)) n = 11'(svg_pkg::MAX_SEGMENTS);
    else                                            n = segments;
    cur.kind     = kind;
    cur.n        = n;
    cur.m        = n + {10'd0, n[0]};
    cur.half     = cur.m >> 1;
    cur.vert     = height >= width;
    cur.width    = width;
    cur.height   = height;
    cur.center_x = center_x;
    cur.center_y = center_y;
    rad          = cur.vert ? width : height;
    len          = {1'b0, (cur.vert ? height : width)};
    if (len == {1'b0, rad}) len = len + 26'd1;
    den[0] = len;
    den[1] = {1'b0, width};
    den[2] = {1'b0, height};
    for (int u = 0; u < 3; u++) ratio[u] = (den[u] == '0) ? '0 : quo[u];
    cur.rx  = ratio[1];
    cur.ry  = ratio[2];
    cur.bar = 17'(svg_pkg::UNIT_ONE) - ratio[0];
  end

  // Restoring divider, one quotient bit per cycle: (rad*2^16 + den/2) / den
  always_ff @(posedge clk) begin
    if (rst) begin
      start <= 1'b1;
      cnt   <= '0;
    end else if (cfg.valid) begin
      start <= 1'b1;
      cnt   <= '0;
    end else if (start) begin
      start <= 1'b0;
      cnt   <= svg_pkg::RCNT_W'(svg_pkg::RDIV_STEPS);
    end else if (cnt != '0) begin
      cnt <= cnt - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    for (int u = 0; u < 3; u++) begin
      if (start) begin
        dvd[u] <= {1'b0, rad, 16'd0} + {17'd0, den[u][svg_pkg::DIM_W:1]};
        rem[u] <= '0;
        quo[u] <= '0;
      end else if (cnt != '0) begin
        if ({rem[u], dvd[u][svg_pkg::RDIV_STEPS-1]} >= {1'b0, den[u]}) begin
          rem[u] <= 26'({rem[u], dvd[u][svg_pkg::RDIV_STEPS-1]} - {1'b0, den[u]});
          quo[u] <= {quo[u][svg_pkg::RATIO_W-2:0], 1'b1};
        end else begin
          rem[u] <= 26'({rem[u], dvd[u][svg_pkg::RDIV_STEPS-1]});
          quo[u] <= {quo[u][svg_pkg::RATIO_W-2:0], 1'b0};
        end
        dvd[u] <= {dvd[u][svg_pkg::RDIV_STEPS-2:0], 1'b0};
      end
    end
  end

  assign busy = start || (cnt != '0);

endmodule

[hdl/svg_front.sv]
// Front end: takes a vertex index beat, checks range and classifies the vertex.
// Depends on svg_pkg and svg_req_if.
module svg_front (
  svg_req_if.sink        req,
  input  svg_pkg::cfg_t  cur,
  input  logic           busy,
  input  logic           full,
  output logic           push,
  output svg_pkg::item_t item
);

  logic [svg_pkg::IDX_W-1:0] j;
  logic [svg_pkg::IDX_W-1:0] count;

  assign req.ready = !busy && !full;
  assign push      = req.valid && req.ready;
  assign j         = req.vertex_index;

  always_comb begin
    item = '0;
    unique case (cur.kind)
      svg_pkg::KIND_CIRC:                    count = cur.n;
      svg_pkg::KIND_TRI, svg_pkg::KIND_RTRI: count = 11'd3;
      svg_pkg::KIND_CAPS:                    count = cur.m + 11'd2;
      default:                               count = 11'd4;
    endcase
    item.in_range = j < count;
    item.last     = j == (count - 11'd1);
    item.den      = cur.n;
    item.idx      = j;

    unique case (cur.kind)
      svg_pkg::KIND_CIRC: begin
        item.arc    = 1'b1;
        item.back_q = 1'b1;
      end
      svg_pkg::KIND_CAPS: begin
        item.arc    = 1'b1;
        item.caps   = 1'b1;
        item.back_q = !cur.vert;
        item.den    = cur.m;
        // seam points: start and half way repeat an arc point on the far side
        if (j == '0) begin
          item.idx = '0;
          item.neg = 1'b1;
        end else if (j <= cur.half + 11'd1) begin
          item.idx = j - 11'd1;
        end else if (j == cur.half + 11'd2) begin
          item.idx = cur.half;
          item.neg = 1'b1;
        end else begin
          item.idx = j - 11'd2;
          item.neg = 1'b1;
        end
      end
      svg_pkg::KIND_TRI: begin
        unique case (j[1:0])
          2'd0:    begin item.corner_x = svg_pkg::CRN_NEG;  item.corner_y = svg_pkg::CRN_POS; end
          2'd1:    begin item.corner_x = svg_pkg::CRN_ZERO; item.corner_y = svg_pkg::CRN_NEG; end
          default: begin item.corner_x = svg_pkg::CRN_POS;  item.corner_y = svg_pkg::CRN_POS; end
        endcase
      end
      svg_pkg::KIND_RTRI: begin
        unique case (j[1:0])
          2'd0:    begin item.corner_x = svg_pkg::CRN_NEG; item.corner_y = svg_pkg::CRN_POS; end
          2'd1:    begin item.corner_x = svg_pkg::CRN_NEG; item.corner_y = svg_pkg::CRN_NEG; end
          default: begin item.corner_x = svg_pkg::CRN_POS; item.corner_y = svg_pkg::CRN_POS; end
        endcase
      end
      default: begin
        unique case (j[1:0])
          2'd0:    begin item.corner_x = svg_pkg::CRN_NEG; item.corner_y = svg_pkg::CRN_POS; end
          2'd1:    begin item.corner_x = svg_pkg::CRN_NEG; item.corner_y = svg_pkg::CRN_NEG; end
          2'd2:    begin item.corner_x = svg_pkg::CRN_POS; item.corner_y = svg_pkg::CRN_NEG; end
          default: begin item.corner_x = svg_pkg::CRN_POS; item.corner_y = svg_pkg::CRN_POS; end
        endcase
      end
    endcase
  end

endmodule

[hdl/svg_fifo.sv]
// Four-entry queue of classified items between front and back.
// Depends on svg_pkg.
module svg_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  svg_pkg::item_t push_item,
  input  logic           pop,
  output logic           full,
  output logic           head_valid,
  output svg_pkg::item_t head
);

  svg_pkg::item_t mem [4];
  logic [1:0]     wr_ptr;
  logic [1:0]     rd_ptr;
  logic [2:0]     fill;

  assign full       = fill == 3'd4;
  assign head_valid = fill != 3'd0;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      fill <= fill + {2'd0, push} - {2'd0, pop};
    end
  end

endmodule

[hdl/svg_back.sv]
// Back end: angle divider, CORDIC, capsule scaling, position and texture mapping.
// Depends on svg_pkg and svg_rsp_if; one shared advance enable for all stages.
module svg_back (
  input  logic           clk,
  input  logic           rst,
  input  svg_pkg::cfg_t  cur,
  input  logic           head_valid,
  input  svg_pkg::item_t head,
  output logic           pop,
  svg_rsp_if.source      rsp
);

  localparam int DN = svg_pkg::DIV_STEPS;
  localparam int CN = svg_pkg::CORDIC_STEPS;

  logic en;

  // Divider stages
  logic                      d_vld [DN+1];
  svg_pkg::item_t            d_itm [DN+1];
  logic [svg_pkg::IDX_W-1:0] d_rem [DN+1];
  logic [31:0]               d_quo [DN+1];

  // CORDIC stages
  logic                          c_vld [CN+1];
  svg_pkg::item_t                c_itm [CN+1];
  logic [1:0]                    c_q   [CN+1];
  logic signed [svg_pkg::CW-1:0] c_x   [CN+1];
  logic signed [svg_pkg::CW-1:0] c_y   [CN+1];
  logic signed [svg_pkg::CW-1:0] c_z   [CN+1];

  // Later stages
  logic                             r_vld, m1_vld, u_vld, m2_vld;
  svg_pkg::item_t                   r_itm, m1_itm, u_itm, m2_itm;
  logic signed [svg_pkg::DIR_W-1:0] r_dx, r_dy, m1_dx, m1_dy;
  logic signed [35:0]               m1_px, m1_py;
  logic signed [svg_pkg::UW-1:0]    u_x, u_y, m2_x, m2_y;
  logic signed [46:0]               m2_px, m2_py;

  // Output register
  logic                             o_valid;
  logic signed [svg_pkg::POS_W-1:0] o_pos_x, o_pos_y;
  logic [svg_pkg::TEX_W-1:0]        o_tex_u, o_tex_v;
  logic                             o_in_range, o_last;

  assign en  = !o_valid || rsp.ready;
  assign pop = en && head_valid;

  // Divider entry: remainder starts at the index (index < divisor)
  always_ff @(posedge clk) begin
    if (rst)     d_vld[0] <= 1'b0;
    else if (en) d_vld[0] <= head_valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_itm[0] <= head;
      d_rem[0] <= head.idx;
      d_quo[0] <= '0;
    end
  end

  // One quotient bit per stage: (idx*2^32 + den/2) / den
  for (genvar k = 1; k <= DN; k++) begin : g_div
    logic [svg_pkg::IDX_W:0] t;
    logic                    nbit;
    logic [31:0]             low;
    assign low  = {21'd0, 1'b0, d_itm[k-1].den[svg_pkg::IDX_W-1:1]};
    assign nbit = low[DN-k];
    assign t    = {d_rem[k-1], nbit};
    always_ff @(posedge clk) begin
      if (rst)     d_vld[k] <= 1'b0;
      else if (en) d_vld[k] <= d_vld[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        d_itm[k] <= d_itm[k-1];
        if (t >= {1'b0, d_itm[k-1].den}) begin
          d_rem[k] <= 11'(t - {1'b0, d_itm[k-1].den});
          d_quo[k] <= {d_quo[k-1][30:0], 1'b1};
        end else begin
          d_rem[k] <= 11'(t);
          d_quo[k] <= {d_quo[k-1][30:0], 1'b0};
        end
      end
    end
  end

  // Angle prep: quarter-turn fold, residual angle into z
  logic [31:0] a_p, a_t;
  logic [1:0]  a_q;
  always_comb begin
    a_p = d_quo[DN] - (d_itm[DN].back_q ? svg_pkg::QUARTER_TURN : 32'd0);
    a_q = 2'((a_p + svg_pkg::EIGHTH_TURN) >> 30);
    a_t = a_p - {a_q, 30'd0};
  end
  always_ff @(posedge clk) begin
    if (rst)     c_vld[0] <= 1'b0;
    else if (en) c_vld[0] <= d_vld[DN];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c_itm[0] <= d_itm[DN];
      c_q[0]   <= a_q;
      c_x[0]   <= svg_pkg::GAIN_Q30;
      c_y[0]   <= '0;
      c_z[0]   <= {{2{a_t[31]}}, a_t};
    end
  end

  // CORDIC rotation, one micro-rotation per stage
  for (genvar k = 1; k <= CN; k++) begin : g_cordic
    logic signed [svg_pkg::CW-1:0] dx, dy, at;
    assign dx = c_y[k-1] >>> (k-1);
    assign dy = c_x[k-1] >>> (k-1);
    assign at = {2'b00, svg_pkg::atan_turn(5'(k-1))};
    always_ff @(posedge clk) begin
      if (rst)     c_vld[k] <= 1'b0;
      else if (en) c_vld[k] <= c_vld[k-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        c_itm[k] <= c_itm[k-1];
        c_q[k]   <= c_q[k-1];
        if (!c_z[k-1][svg_pkg::CW-1]) begin
          c_x[k] <= c_x[k-1] - dx;
          c_y[k] <= c_y[k-1] + dy;
          c_z[k] <= c_z[k-1] - at;
        end else begin
          c_x[k] <= c_x[k-1] + dx;
          c_y[k] <= c_y[k-1] - dy;
          c_z[k] <= c_z[k-1] + at;
        end
      end
    end
  end

  // Quadrant restore, round to Q1.16 and clamp; corners for fixed outlines
  function automatic logic signed [svg_pkg::DIR_W-1:0] to_unit(
      input logic signed [svg_pkg::CW-1:0] v);
    logic signed [svg_pkg::CW-1:0] r;
    r = (v + 34'sd8192) >>> 14;
    if (r > 34'sd65536)       return svg_pkg::UNIT_ONE;
    else if (r < -34'sd65536) return -svg_pkg::UNIT_ONE;
    else                      return r[svg_pkg::DIR_W-1:0];
  endfunction

  function automatic logic signed [svg_pkg::DIR_W-1:0] corner(input logic [1:0] c);
    logic signed [svg_pkg::DIR_W-1:0] r;
    unique case (c)
      svg_pkg::CRN_POS: r = svg_pkg::UNIT_ONE;
      svg_pkg::CRN_NEG: r = -svg_pkg::UNIT_ONE;
      default:          r = '0;
    endcase
    return r;
  endfunction

  logic signed [svg_pkg::CW-1:0] q_c, q_s;
  always_comb begin
    unique case (c_q[CN])
      2'd1:    begin q_c = -c_y[CN]; q_s = c_x[CN];  end
      2'd2:    begin q_c = -c_x[CN]; q_s = -c_y[CN]; end
      2'd3:    begin q_c = c_y[CN];  q_s = -c_x[CN]; end
      default: begin q_c = c_x[CN];  q_s = c_y[CN];  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_vld  <= 1'b0;
      m1_vld <= 1'b0;
      u_vld  <= 1'b0;
      m2_vld <= 1'b0;
    end else if (en) begin
      r_vld  <= c_vld[CN];
      m1_vld <= r_vld;
      u_vld  <= m1_vld;
      m2_vld <= u_vld;
    end
  end

  // Capsule scaling: round(dir * ratio / 2^16) plus the bar offset
  logic signed [svg_pkg::UW-1:0] sx, sy, bar_s;
  always_comb begin
    sx    = 21'((m1_px + 36'sd32768) >>> 16);
    sy    = 21'((m1_py + 36'sd32768) >>> 16);
    bar_s = m1_itm.neg ? -$signed({4'd0, cur.bar}) : $signed({4'd0, cur.bar});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_itm  <= c_itm[CN];
      r_dx   <= c_itm[CN].arc ? to_unit(q_c) : corner(c_itm[CN].corner_x);
      r_dy   <= c_itm[CN].arc ? to_unit(q_s) : corner(c_itm[CN].corner_y);
      m1_itm <= r_itm;
      m1_dx  <= r_dx;
      m1_dy  <= r_dy;
      m1_px  <= $signed(36'(r_dx)) * $signed(36'({1'b0, cur.rx}));
      m1_py  <= $signed(36'(r_dy)) * $signed(36'({1'b0, cur.ry}));
      u_itm  <= m1_itm;
      if (m1_itm.caps) begin
        u_x <= cur.vert ? sx : sx + bar_s;
        u_y <= cur.vert ? sy + bar_s : sy;
      end else begin
        u_x <= 21'(m1_dx);
        u_y <= 21'(m1_dy);
      end
      m2_itm <= u_itm;
      m2_x   <= u_x;
      m2_y   <= u_y;
      m2_px  <= $signed(47'(u_x)) * $signed(47'({1'b0, cur.width}));
      m2_py  <= $signed(47'(u_y)) * $signed(47'({1'b0, cur.height}));
    end
  end

  // Position: round(product / 2^17) + center, saturated
  function automatic logic signed [svg_pkg::POS_W-1:0] to_pos(
      input logic signed [46:0] p, input logic signed [svg_pkg::CTR_W-1:0] c);
    logic signed [31:0] s;
    s = 32'((p + 47'sd65536) >>> 17) + 32'(c);
    if (s > 32'(svg_pkg::POS_MAX))      return svg_pkg::POS_MAX;
    else if (s < 32'(svg_pkg::POS_MIN)) return svg_pkg::POS_MIN;
    else                                return s[svg_pkg::POS_W-1:0];
  endfunction

  // Texture: (clamp(u) + 1 + 2^-16) / 2
  function automatic logic [svg_pkg::TEX_W-1:0] to_tex(
      input logic signed [svg_pkg::UW-1:0] u);
    logic signed [svg_pkg::UW-1:0] c;
    logic signed [svg_pkg::UW-1:0] s;
    if (u > 21'sd65536)       c = 21'sd65536;
    else if (u < -21'sd65536) c = -21'sd65536;
    else                      c = u;
    s = (c + 21'sd65537) >>> 1;
    return s[svg_pkg::TEX_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst)           o_valid <= 1'b0;
    else if (en)       o_valid <= m2_vld;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      o_in_range <= m2_itm.in_range;
      if (m2_itm.in_range) begin
        o_pos_x <= to_pos(m2_px, cur.center_x);
        o_pos_y <= to_pos(m2_py, cur.center_y);
        o_tex_u <= to_tex(m2_x);
        o_tex_v <= to_tex(m2_y);
        o_last  <= m2_itm.last;
      end else begin
        o_pos_x <= '0;
        o_pos_y <= '0;
        o_tex_u <= '0;
        o_tex_v <= '0;
        o_last  <= 1'b0;
      end
    end
  end

  assign rsp.valid       = o_valid;
  assign rsp.pos_x       = o_pos_x;
  assign rsp.pos_y       = o_pos_y;
  assign rsp.tex_u       = o_tex_u;
  assign rsp.tex_v       = o_tex_v;
  assign rsp.in_range    = o_in_range;
  assign rsp.last_vertex = o_last;

endmodule

[hdl/shape_vertex_generator.sv]
// Top level of the shape vertex generator: config block, front, queue and back.
// Depends on svg_pkg, svg_if, svg_cfg, svg_front, svg_fifo and svg_back.
//
//  Port  Dir  Payload                                             Beat
//  req   in   vertex_index                                        one vertex request
//  rsp   out  pos_x pos_y tex_u tex_v in_range last_vertex        one vertex result
//  cfg   in   index data                                          one register write
//
// One vertex per clock while req is ready and rsp is not stalled; the path runs
// through the 32-stage angle divider and the 16-stage CORDIC. A register write,
// and reset, start a serial ratio division during which req is not ready. A
// stall on rsp freezes the back pipeline; the four-entry queue takes req till full.
module shape_vertex_generator (
  input logic       clk,
  input logic       rst,
  svg_req_if.sink   req,
  svg_rsp_if.source rsp,
  svg_cfg_if.sink   cfg
);

  svg_pkg::cfg_t  cur;
  svg_pkg::item_t push_item;
  svg_pkg::item_t head;
  logic           busy;
  logic           full;
  logic           push;
  logic           pop;
  logic           head_valid;

  svg_cfg u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .cur  (cur),
    .busy (busy)
  );

  svg_front u_front (
    .req  (req),
    .cur  (cur),
    .busy (busy),
    .full (full),
    .push (push),
    .item (push_item)
  );

  svg_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head       (head)
  );

  svg_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cur        (cur),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule
